FILE: rtl/adbp_pkg.sv
// ----------------------------------------------------------------------------
// adbp_pkg: shared constants for the address delta bit packer
// Default sizes, prefix codes of the delta coder and the queue depth.
// ----------------------------------------------------------------------------
package adbp_pkg;

   // default sizes
   localparam int ADDR_BITS_DEF        = 48;
   localparam int SHORT_DELTA_BITS_DEF = 16;

   // depth of the queue between classifier and packer (power of two)
   localparam int QUEUE_DEPTH = 4;

   localparam int BYTE_BITS = 8;

   // prefix codes, first stream bit on the left
   localparam logic [0:0] CODE_UP1   = 1'b0;
   localparam logic [1:0] CODE_DN1   = 2'b10;
   localparam logic [2:0] CODE_SHORT = 3'b110;
   localparam logic [2:0] CODE_LONG  = 3'b111;

endpackage

FILE: rtl/adbp_front.sv
// ----------------------------------------------------------------------------
// adbp_front: request classifier
// Compares each address with the previous one and forms a left-aligned code
// word with its length; tracks the start of a trace.
// ----------------------------------------------------------------------------
module adbp_front
   import adbp_pkg::*;
#(
   parameter int ADDR_BITS        = ADDR_BITS_DEF,
   parameter int SHORT_DELTA_BITS = SHORT_DELTA_BITS_DEF,
   localparam int MAX_FIELD = (ADDR_BITS > SHORT_DELTA_BITS) ? ADDR_BITS : SHORT_DELTA_BITS,
   localparam int CODE_W    = MAX_FIELD + 3,
   localparam int LEN_W     = $clog2(CODE_W + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [ADDR_BITS-1:0] in_address,
   input  logic                 in_end,
   input  logic                 push,
   output logic [CODE_W-1:0]    code,
   output logic [LEN_W-1:0]     code_len,
   output logic                 code_end
);

   localparam int DW = ADDR_BITS + 1;
   localparam int EW = (DW > SHORT_DELTA_BITS) ? DW : SHORT_DELTA_BITS;

   logic [ADDR_BITS-1:0] prev_addr_ff, prev_addr_in;
   logic                 first_ff, first_in;

   logic signed [DW-1:0] delta;
   logic signed [EW-1:0] delta_ext;
   logic [EW-SHORT_DELTA_BITS:0] sign_bits;
   logic                 is_up1, is_dn1, is_short;

   assign delta     = $signed({1'b0, in_address}) - $signed({1'b0, prev_addr_ff});
   assign delta_ext = EW'(delta);
   assign sign_bits = delta_ext[EW-1:SHORT_DELTA_BITS-1];
   assign is_up1    = (delta == DW'(1));
   assign is_dn1    = &delta;
   assign is_short  = (&sign_bits) | ~(|sign_bits);

   always_comb begin
      if (first_ff) begin
         code     = CODE_W'(in_address) << (CODE_W - ADDR_BITS);
         code_len = LEN_W'(ADDR_BITS);
      end else if (is_up1) begin
         code     = CODE_W'(CODE_UP1) << (CODE_W - 1);
         code_len = LEN_W'(1);
      end else if (is_dn1) begin
         code     = CODE_W'(CODE_DN1) << (CODE_W - 2);
         code_len = LEN_W'(2);
      end else if (is_short) begin
         code     = CODE_W'({CODE_SHORT, delta_ext[SHORT_DELTA_BITS-1:0]})
                    << (CODE_W - 3 - SHORT_DELTA_BITS);
         code_len = LEN_W'(3 + SHORT_DELTA_BITS);
      end else begin
         code     = CODE_W'({CODE_LONG, in_address}) << (CODE_W - 3 - ADDR_BITS);
         code_len = LEN_W'(3 + ADDR_BITS);
      end
   end

   assign code_end = in_end;

   // advance the trace state on each pushed request
   always_comb begin
      prev_addr_in = prev_addr_ff;
      first_in     = first_ff;
      if (in_valid && push) begin
         prev_addr_in = in_address;
         first_in     = in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_addr_ff <= '0;
         first_ff     <= 1'b1;
      end else begin
         prev_addr_ff <= prev_addr_in;
         first_ff     <= first_in;
      end
   end

endmodule

FILE: rtl/adbp_queue.sv
// ----------------------------------------------------------------------------
// adbp_queue: small register queue
// Holds classified code words between classifier and packer.
// ----------------------------------------------------------------------------
module adbp_queue
   import adbp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/adbp_back.sv
// ----------------------------------------------------------------------------
// adbp_back: bit packer
// Appends code words to a left-aligned bit buffer and emits one byte per cycle
// through an output register unless the output stalls; pads and flags a trace end.
// ----------------------------------------------------------------------------
module adbp_back
   import adbp_pkg::*;
#(
   parameter int ADDR_BITS        = ADDR_BITS_DEF,
   parameter int SHORT_DELTA_BITS = SHORT_DELTA_BITS_DEF,
   localparam int MAX_FIELD = (ADDR_BITS > SHORT_DELTA_BITS) ? ADDR_BITS : SHORT_DELTA_BITS,
   localparam int CODE_W    = MAX_FIELD + 3,
   localparam int LEN_W     = $clog2(CODE_W + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 code_valid,
   output logic                 code_ready,
   input  logic [CODE_W-1:0]    code,
   input  logic [LEN_W-1:0]     code_len,
   input  logic                 code_end,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [BYTE_BITS-1:0] out_byte,
   output logic                 out_last
);

   localparam int BUF_W = CODE_W + BYTE_BITS - 1;
   localparam int CNT_W = $clog2(BUF_W + 1);

   logic [BUF_W-1:0]     buf_ff, buf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 end_ff, end_in;
   logic                 valid_ff, valid_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 can_out, full_byte;

   assign can_out    = !valid_ff || out_ready;
   assign full_byte  = (cnt_ff >= CNT_W'(BYTE_BITS));
   assign code_ready = !full_byte && !end_ff;

   always_comb begin
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      end_in   = end_ff;
      valid_in = valid_ff && !out_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (full_byte) begin
         // emit a whole byte
         if (can_out) begin
            valid_in = 1'b1;
            byte_in  = buf_ff[BUF_W-1 -: BYTE_BITS];
            last_in  = end_ff && (cnt_ff == CNT_W'(BYTE_BITS));
            buf_in   = buf_ff << BYTE_BITS;
            cnt_in   = cnt_ff - CNT_W'(BYTE_BITS);
            if (end_ff && (cnt_ff == CNT_W'(BYTE_BITS))) begin
               end_in = 1'b0;
            end
         end
      end else if (end_ff) begin
         // flush the zero-padded partial byte
         if (cnt_ff == '0) begin
            end_in = 1'b0;
         end else if (can_out) begin
            valid_in = 1'b1;
            byte_in  = buf_ff[BUF_W-1 -: BYTE_BITS];
            last_in  = 1'b1;
            buf_in   = '0;
            cnt_in   = '0;
            end_in   = 1'b0;
         end
      end else if (code_valid) begin
         // append the next code word behind the held bits
         buf_in = buf_ff | ({code, {(BYTE_BITS - 1){1'b0}}} >> cnt_ff[2:0]);
         cnt_in = cnt_ff + CNT_W'(code_len);
         end_in = code_end;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         cnt_ff   <= '0;
         end_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         end_ff   <= end_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

FILE: rtl/address_delta_bit_packer.sv
// ----------------------------------------------------------------------------
// address_delta_bit_packer: delta-prefix coder for address traces
// Codes each address against the previous one and packs the codes MSB-first
// into a byte stream.
// ----------------------------------------------------------------------------
// Each request carries one address (tdata) and tlast on the final address of
// a trace. The first address of a trace goes out as ADDR_BITS raw bits; each
// later one as "0" for +1, "10" for -1, "110" plus a SHORT_DELTA_BITS two's
// complement difference when it fits, else "111" plus the raw address. The
// difference is exact (no wrap at the address edge). Bytes leave first stream
// bit in bit 7; at the end of a trace the partial byte is zero-padded and the
// final byte carries tlast. Throughput: the classifier accepts one request
// per cycle while its queue (QUEUE_DEPTH entries) has room; the packer
// appends a code word only while it holds less than a whole byte and no
// pending trace end, and sends each completed byte and the padded flush at
// a trace end out as a step of its own. The packer's single byte output
// port sets the sustained rate; +1 and -1 codes run at close to one request
// per cycle while the output does not stall, pausing for each byte they
// fill, and the queue absorbs bursts of longer codes. A request's first
// byte passes through the queue, the bit buffer and the output register to
// rsp_tvalid, and waits longer under output stalls or a queue backlog.
// ----------------------------------------------------------------------------
module address_delta_bit_packer
   import adbp_pkg::*;
#(
   parameter int ADDR_BITS        = ADDR_BITS_DEF,
   parameter int SHORT_DELTA_BITS = SHORT_DELTA_BITS_DEF,
   localparam int TDATA_W = ((ADDR_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // [ADDR_BITS-1:0] address, rest zero
   input  logic                 req_tlast,   // trace_end
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_BITS-1:0] rsp_tdata,   // [7:0] out_byte
   output logic                 rsp_tlast    // out_last
);

   localparam int MAX_FIELD = (ADDR_BITS > SHORT_DELTA_BITS) ? ADDR_BITS : SHORT_DELTA_BITS;
   localparam int CODE_W    = MAX_FIELD + 3;
   localparam int LEN_W     = $clog2(CODE_W + 1);
   localparam int ENTRY_W   = CODE_W + LEN_W + 1;

   logic [CODE_W-1:0]  f_code, q_code;
   logic [LEN_W-1:0]   f_len, q_len;
   logic               f_end, q_end;
   logic               q_valid, q_ready;
   logic [ENTRY_W-1:0] q_out;

   // classify each request against the previous address
   adbp_front #(
      .ADDR_BITS        (ADDR_BITS),
      .SHORT_DELTA_BITS (SHORT_DELTA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_address (req_tdata[ADDR_BITS-1:0]),
      .in_end     (req_tlast),
      .push       (req_tready),
      .code       (f_code),
      .code_len   (f_len),
      .code_end   (f_end)
   );

   // decouple classifier and packer
   adbp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({f_end, f_len, f_code}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   assign q_code = q_out[CODE_W-1:0];
   assign q_len  = q_out[CODE_W +: LEN_W];
   assign q_end  = q_out[ENTRY_W-1];

   // pack code words into bytes
   adbp_back #(
      .ADDR_BITS        (ADDR_BITS),
      .SHORT_DELTA_BITS (SHORT_DELTA_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .code_valid (q_valid),
      .code_ready (q_ready),
      .code       (q_code),
      .code_len   (q_len),
      .code_end   (q_end),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

FILE: sim/trace_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_code_checker: byte-stream checker for the address delta bit packer
// Watches both channels. Codes each accepted address into the bytes it must
// produce and compares every output byte with the oldest one still due.
// ----------------------------------------------------------------------------
module trace_code_checker
   import adbp_pkg::*;
#(
   parameter int ADDR_BITS        = ADDR_BITS_DEF,
   parameter int SHORT_DELTA_BITS = SHORT_DELTA_BITS_DEF,
   localparam int TDATA_W = ((ADDR_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // [ADDR_BITS-1:0] address, rest zero
   input  logic                 req_tlast,   // trace_end
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [BYTE_BITS-1:0] rsp_tdata,   // [7:0] out_byte
   input  logic                 rsp_tlast,   // out_last
   output int                   mismatch_count,
   output int                   bytes_outstanding,
   output int                   bytes_checked
);

   localparam longint SHORT_MIN = -(longint'(1) << (SHORT_DELTA_BITS - 1));
   localparam longint SHORT_MAX = (longint'(1) << (SHORT_DELTA_BITS - 1)) - 1;
   localparam int     MAX_PRINTED = 100;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
   } coded_byte_t;

   coded_byte_t          bytes_due[$];
   logic [ADDR_BITS-1:0] prev_addr;
   logic                 expect_first;
   logic [BYTE_BITS-1:0] partial_byte;
   int                   partial_count;

   initial begin
      mismatch_count    = 0;
      bytes_outstanding = 0;
      bytes_checked     = 0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t ns: MISMATCH %s", $realtime, what);
      end
   endtask

   // shift bits in MSB-first, emit each byte as soon as it fills
   task automatic append_bits(input logic [63:0] value, input int width);
      coded_byte_t full;
      int          i;
      for (i = width - 1; i >= 0; i--) begin
         partial_byte = {partial_byte[BYTE_BITS-2:0], value[i]};
         partial_count++;
         if (partial_count == BYTE_BITS) begin
            full.data = partial_byte;
            full.last = 1'b0;
            bytes_due.push_back(full);
            partial_byte  = '0;
            partial_count = 0;
         end
      end
   endtask

   task automatic code_address(input logic [ADDR_BITS-1:0] addr, input logic trace_end);
      logic signed [ADDR_BITS:0] delta;
      coded_byte_t               tail;
      int                        queued_before;
      queued_before = bytes_due.size();
      if (expect_first) begin
         append_bits(64'(addr), ADDR_BITS);
         expect_first = 1'b0;
      end else begin
         // exact difference, one extra bit so the address edge never wraps
         delta = {1'b0, addr} - {1'b0, prev_addr};
         if (delta == 1) begin
            append_bits(64'(CODE_UP1), 1);
         end else if (delta == -1) begin
            append_bits(64'(CODE_DN1), 2);
         end else if (delta >= SHORT_MIN && delta <= SHORT_MAX) begin
            append_bits(64'(CODE_SHORT), 3);
            append_bits(64'(delta[SHORT_DELTA_BITS-1:0]), SHORT_DELTA_BITS);
         end else begin
            append_bits(64'(CODE_LONG), 3);
            append_bits(64'(addr), ADDR_BITS);
         end
      end
      prev_addr = addr;
      if (trace_end) begin
         if (partial_count > 0) begin
            tail.data = partial_byte << (BYTE_BITS - partial_count);
            tail.last = 1'b1;
            bytes_due.push_back(tail);
            partial_byte  = '0;
            partial_count = 0;
         end else if (bytes_due.size() > queued_before) begin
            // byte boundary hit exactly: flag the byte this request completed
            tail = bytes_due.pop_back();
            tail.last = 1'b1;
            bytes_due.push_back(tail);
         end
         expect_first = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      coded_byte_t want;
      if (reset) begin
         bytes_due.delete();
         prev_addr     = '0;
         expect_first  = 1'b1;
         partial_byte  = '0;
         partial_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            code_address(req_tdata[ADDR_BITS-1:0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("byte %02h last %0b with nothing due",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = bytes_due.pop_front();
               bytes_checked++;
               if (rsp_tdata !== want.data) begin
                  report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                            bytes_checked, rsp_tdata, want.data));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("byte %0d: out_last %0b, want %0b",
                                            bytes_checked, rsp_tlast, want.last));
               end
            end
         end
      end
      bytes_outstanding <= bytes_due.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the address delta bit packer
// Feeds directed and random address traces with random gaps and output
// stalls; a side checker predicts the byte stream and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
   import adbp_pkg::*;

   localparam int ADDR_BITS        = ADDR_BITS_DEF;
   localparam int SHORT_DELTA_BITS = SHORT_DELTA_BITS_DEF;
   localparam int TDATA_W          = ((ADDR_BITS + 7) / 8) * 8;
   localparam int MAX_WAIT         = 18;
   localparam int RANDOM_PHASES    = 4;
   localparam int PHASE_REQUESTS   = 22;
   localparam int QUIET_CYCLES     = 40;
   // ~130 requests, each with its longest gap and up to 8 stalled bytes
   localparam int CYCLE_LIMIT      = 300000;

   // kinds of step inside a random trace
   typedef enum int {
      STEP_UP1,
      STEP_DN1,
      STEP_SHORT,
      STEP_SHORT_EDGE,
      STEP_LONG,
      STEP_REPEAT
   } step_kind_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BYTE_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   int   mismatch_count;
   int   bytes_outstanding;
   int   bytes_checked;
   int   requests_sent = 0;
   int   traces_sent   = 0;
   int   cycle_count   = 0;
   logic steady = 1'b0;   // set: neither side idles

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   address_delta_bit_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   trace_code_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding),
      .bytes_checked     (bytes_checked)
   );

   // Abort a hung run; the limit is far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due",
                  cycle_count, bytes_outstanding);
         $display("address_delta_bit_packer test failed");
         $finish;
      end
   end

   function automatic int draw_wait();
      if (steady || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Output side: stall for a drawn number of cycles before each byte, then
   // hold tready high until the byte is taken.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Drive one request after a drawn gap and hold it until accepted.
   task automatic send_address(input logic [ADDR_BITS-1:0] addr, input logic trace_end);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         // drop valid and scramble the bus so idle data can't leak in
         req_tvalid <= 1'b0;
         req_tdata  <= TDATA_W'({$urandom(), $urandom()});
         req_tlast  <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tlast  <= trace_end;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      requests_sent++;
      if (trace_end) begin
         traces_sent++;
      end
   endtask

   // Send one well-formed trace of random length with a mix of step kinds.
   task automatic send_random_trace();
      logic [ADDR_BITS-1:0] addr;
      longint               delta;
      int                   length;
      int                   roll;
      int                   n;
      step_kind_t           kind;
      length = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      addr   = ADDR_BITS'({$urandom(), $urandom()});
      for (n = 0; n < length; n++) begin
         if (n > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      kind = STEP_UP1;
            else if (roll < 58) kind = STEP_DN1;
            else if (roll < 75) kind = STEP_SHORT;
            else if (roll < 82) kind = STEP_SHORT_EDGE;
            else if (roll < 95) kind = STEP_LONG;
            else                kind = STEP_REPEAT;
            case (kind)
               STEP_UP1: begin
                  addr = addr + 1'b1;
               end
               STEP_DN1: begin
                  addr = addr - 1'b1;
               end
               STEP_SHORT: begin
                  delta = longint'($urandom_range(0, 65535)) - 32768;
                  addr  = addr + ADDR_BITS'(delta);
               end
               STEP_SHORT_EDGE: begin
                  // land on either side of the short-delta range bounds
                  case ($urandom_range(0, 3))
                     0:       delta = 32767;
                     1:       delta = -32768;
                     2:       delta = 32768;
                     default: delta = -32769;
                  endcase
                  addr = addr + ADDR_BITS'(delta);
               end
               STEP_LONG: begin
                  case ($urandom_range(0, 5))
                     0:       addr = '1;
                     1:       addr = '0;
                     default: addr = ADDR_BITS'({$urandom(), $urandom()});
                  endcase
               end
               default: begin
                  // zero difference: coded as a short delta
               end
            endcase
         end
         send_address(addr, n == length - 1);
      end
   endtask

   initial begin
      logic [ADDR_BITS-1:0] base;
      int                   phase;
      int                   phase_start;
      int                   k;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-address traces at both ends of the address range
      send_address('0, 1'b1);
      send_address('1, 1'b1);

      // every code, the short-range bounds and the address-edge wrap
      base = 48'h0000_1234_0000;
      send_address(base, 1'b0);
      send_address(base + 1, 1'b0);             // up by one
      send_address(base, 1'b0);                 // down by one
      send_address(base + 32767, 1'b0);         // largest positive short
      send_address(base - 1, 1'b0);             // most negative short
      send_address(base + 32767, 1'b0);         // just past positive short: long
      send_address(base - 2, 1'b0);             // just past negative short: long
      send_address(base - 2, 1'b0);             // zero difference
      send_address('1, 1'b0);
      send_address('0, 1'b0);                   // all ones to zero is no +1
      send_address('1, 1'b0);
      send_address({{(ADDR_BITS-1){1'b1}}, 1'b0}, 1'b0);
      send_address('1, 1'b1);

      // first address plus eight +1 codes: the trace ends on a byte boundary
      for (k = 0; k < 9; k++) begin
         send_address(ADDR_BITS'(5 + k), k == 8);
      end

      // random traces; one phase runs with no idling on either side
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady      = (phase == 1);
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            send_random_trace();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bytes_outstanding != 0) @(negedge clock);
      // hold a little longer to catch stray bytes
      repeat (QUIET_CYCLES) @(posedge clock);

      $display("sent %0d addresses in %0d traces; checked %0d output bytes",
               requests_sent, traces_sent, bytes_checked);
      $display("covered raw, +1, -1, short and long codes with random gaps and stalls");
      if (mismatch_count == 0) begin
         $display("address_delta_bit_packer test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("address_delta_bit_packer test failed");
      end
      $finish;
   end

endmodule
